FILE: rtl/ptpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants of the vertex transform and perspective divide.
// ----------------------------------------------------------------------------
package ptpd_pkg;

    // opcodes of an input item
    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSFORM = 1'b1;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // matrix geometry
    localparam int MAT_ENTRIES = 16;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_zero;
        logic               saturated;
    } out_t;

    // classified command handed from front to back
    typedef struct packed {
        logic               is_load;
        logic [3:0]         index;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cmd_t;

    // flags traveling beside the divider lanes
    typedef struct packed {
        logic signed [31:0] w;
        logic               wz;
        logic               sat;
    } side_t;

endpackage

FILE: rtl/point_transform_perspective_divide_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_core
// 4x4 fixed-point vertex transform with perspective divide.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ valid/ready channel. A load item writes one
// matrix entry (row*4+column) and yields no result; a transform item yields
// one result on the m_ channel with x,y,z divided by w and the undivided w.
// Every matrix entry used must be loaded first; loads take effect in item
// order, so a transform sees every load that was accepted before it.
// Throughput: one item per cycle, sustained while the result side is not stalled.
// Path of a transform: input register, queue, three multiply/sum stages,
// then the divider: operand capture, one quotient bit per stage over
// 32+FRAC_BITS bits, and an output register.
// Reset clears all valid state; the matrix is not cleared.
// When m_ready is low the back pipeline holds, the queue fills, and s_ready
// drops once the queue and input register are full.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptpd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ptpd_pkg::out_t m_data
);
    import ptpd_pkg::*;

    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // front: accept and classify
    ptpd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_cmd   (f_cmd)
    );

    // command queue
    ptpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    // back: matrix, transform and divide
    ptpd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/ptpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_front
// Input register stage: accepts items and classifies them into commands.
// ----------------------------------------------------------------------------
module ptpd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptpd_pkg::in_t  s_data,
    output logic           f_valid,
    input  logic           f_ready,
    output ptpd_pkg::cmd_t f_cmd
);
    import ptpd_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // register free when empty or draining this cycle
    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_cmd   = cmd_reg;

    // classify the incoming item
    always_comb begin
        cmd_next.is_load = (s_data.opcode == OP_LOAD);
        cmd_next.index   = s_data.entry_index;
        cmd_next.value   = s_data.entry_value;
        cmd_next.x       = s_data.point_x;
        cmd_next.y       = s_data.point_y;
        cmd_next.z       = s_data.point_z;
    end

    // valid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // command payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: rtl/ptpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_queue
// Small command fifo decoupling the front from the back.
// ----------------------------------------------------------------------------
module ptpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ptpd_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ptpd_pkg::cmd_t rd_cmd
);
    import ptpd_pkg::*;

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           push;
    logic           pop;

    assign wr_ready = (count_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: rtl/ptpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_div
// One lane of the pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptpd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [32+FRAC_BITS-1:0]   dividend,
    input  logic [31:0]               divisor,
    input  logic                      neg,
    output logic signed [31:0]        quot,
    output logic                      sat
);
    localparam int N = 32 + FRAC_BITS;

    logic [32:0]  rem_reg [N+1];
    logic [N-1:0] dq_reg  [N+1];
    logic [31:0]  d_reg   [N+1];
    logic         neg_reg [N+1];
    logic signed [31:0] quot_reg;
    logic               sat_reg;

    // operand capture
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= dividend;
            d_reg[0]   <= divisor;
            neg_reg[0] <= neg;
        end
    end

    // one shift-subtract step per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [32:0] trial;
        logic        ge;
        assign trial = {rem_reg[i][31:0], dq_reg[i][N-1]};
        assign ge    = (trial >= {1'b0, d_reg[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? (trial - {1'b0, d_reg[i]}) : trial;
                dq_reg[i+1]  <= {dq_reg[i][N-2:0], ge};
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // sign restore and clip
    logic [N-1:0] mag;
    logic         big_pos;
    logic         big_neg;
    assign mag     = dq_reg[N];
    assign big_pos = (mag[N-1:31] != '0);
    assign big_neg = (mag[N-1:31] > (N-31)'(1)) ||
                     ((mag[N-1:31] == (N-31)'(1)) && (mag[30:0] != '0));

    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[N]) begin
                sat_reg  <= big_neg;
                quot_reg <= big_neg ? 32'sh8000_0000 : -$signed(mag[31:0]);
            end else begin
                sat_reg  <= big_pos;
                quot_reg <= big_pos ? 32'sh7fff_ffff : $signed(mag[31:0]);
            end
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

FILE: rtl/ptpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_back
// Matrix store, row-vector multiply pipeline and perspective divide lanes.
// ----------------------------------------------------------------------------
module ptpd_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  ptpd_pkg::cmd_t q_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output ptpd_pkg::out_t m_data
);
    import ptpd_pkg::*;

    localparam int N   = 32 + FRAC_BITS;
    localparam int LAT = N + 2;

    logic advance;
    logic pop;

    logic signed [31:0] mat_reg [MAT_ENTRIES];

    logic               s0_valid_reg;
    logic signed [63:0] prod_reg [12];
    logic signed [31:0] m3_reg   [4];
    logic               s1_valid_reg;
    logic signed [65:0] sum_reg  [4];
    logic signed [31:0] m3b_reg  [4];
    logic               s2_valid_reg;
    logic signed [31:0] comp_reg [4];
    logic               csat_reg;

    logic [LAT-1:0]     side_valid_reg;
    side_t              side_reg [LAT];

    // whole back pipeline moves unless the result is stalled
    assign advance = !side_valid_reg[LAT-1] || m_ready;
    assign q_ready = advance;
    assign pop     = q_valid && advance;

    // matrix loads in command order
    always_ff @(posedge aclk) begin
        if (pop && q_cmd.is_load) begin
            mat_reg[q_cmd.index] <= q_cmd.value;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            side_valid_reg <= '0;
        end else if (advance) begin
            s0_valid_reg   <= q_valid && !q_cmd.is_load;
            s1_valid_reg   <= s0_valid_reg;
            s2_valid_reg   <= s1_valid_reg;
            side_valid_reg <= {side_valid_reg[LAT-2:0], s2_valid_reg};
        end
    end

    // stage 0: twelve products
    logic signed [31:0] pt [3];
    assign pt[0] = q_cmd.x;
    assign pt[1] = q_cmd.y;
    assign pt[2] = q_cmd.z;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    prod_reg[r*4+c] <= 64'(pt[r]) * 64'(mat_reg[r*4+c]);
                end
            end
            for (int c = 0; c < 4; c++) begin
                m3_reg[c] <= mat_reg[12+c];
            end
        end
    end

    // stage 1: column sums at full precision
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int c = 0; c < 4; c++) begin
                sum_reg[c] <= 66'(prod_reg[c]) + 66'(prod_reg[4+c]) + 66'(prod_reg[8+c]);
                m3b_reg[c] <= m3_reg[c];
            end
        end
    end

    // stage 2: floor, translation and clip
    logic signed [65:0] col [4];
    logic [3:0]         fits;
    logic signed [31:0] comp_next [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            col[c]  = (sum_reg[c] >>> FRAC_BITS) + 66'(m3b_reg[c]);
            fits[c] = (col[c][65:31] == {35{col[c][31]}});
            if (fits[c]) begin
                comp_next[c] = col[c][31:0];
            end else begin
                comp_next[c] = col[c][65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int c = 0; c < 4; c++) begin
                comp_reg[c] <= comp_next[c];
            end
            csat_reg <= !(&fits);
        end
    end

    // divider operands
    logic [31:0]        wmag;
    logic               wz;
    logic signed [31:0] quot [3];
    logic [2:0]         qsat;
    assign wmag = comp_reg[3][31] ? (~comp_reg[3] + 32'd1) : comp_reg[3];
    assign wz   = (comp_reg[3] == '0);

    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [32:0]  mag;
        logic [N-1:0] dvd;
        assign mag = comp_reg[c][31] ? (~{1'b1, comp_reg[c]} + 33'd1)
                                     : {1'b0, comp_reg[c]};
        assign dvd = N'(mag) << FRAC_BITS;
        ptpd_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk     (aclk),
            .en       (advance),
            .dividend (dvd),
            .divisor  (wmag),
            .neg      (comp_reg[c][31] ^ comp_reg[3][31]),
            .quot     (quot[c]),
            .sat      (qsat[c])
        );
    end

    // flags beside the lanes
    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0].w   <= comp_reg[3];
            side_reg[0].wz  <= wz;
            side_reg[0].sat <= csat_reg;
            for (int k = 1; k < LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // result assembly
    side_t last;
    assign last    = side_reg[LAT-1];
    assign m_valid = side_valid_reg[LAT-1];

    always_comb begin
        m_data.out_x     = last.wz ? '0 : quot[0];
        m_data.out_y     = last.wz ? '0 : quot[1];
        m_data.out_z     = last.wz ? '0 : quot[2];
        m_data.out_w     = last.w;
        m_data.w_zero    = last.wz;
        m_data.saturated = last.sat || (!last.wz && (|qsat));
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the vertex transform and perspective divide core: matrix loads and
// point transforms go in on random timing, and every result is compared
// field by field with a directed value or a local run of the same fixed-point math.
// ----------------------------------------------------------------------------
module tb_top;
    import ptpd_pkg::*;

    localparam int FRAC = 16;
    localparam int LIMIT = 400000;
    localparam int DRAIN = 200;
    localparam int N_RAND = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // local copy of the matrix, all entries written before any transform
    logic signed [31:0] mat [MAT_ENTRIES];
    out_t expected_q [$];
    int errors = 0;
    int cycles = 0;
    int stall_cnt = 0;

    point_transform_perspective_divide_core #(.FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [63:0] clip(input logic signed [127:0] v,
                                                 inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v[63:0];
    endfunction

    // transform one point through the matrix and divide by w
    function automatic out_t project_point(input in_t it);
        logic signed [127:0] acc;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        logic signed [63:0] comp [4];
        logic sat;
        out_t r;
        sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            acc = 128'(it.point_x) * 128'(mat[c]) + 128'(it.point_y) * 128'(mat[4 + c])
                + 128'(it.point_z) * 128'(mat[8 + c]);
            acc = (acc >>> FRAC) + 128'(mat[12 + c]);
            comp[c] = clip(acc, sat);
        end
        r = '0;
        r.out_w = comp[3][31:0];
        r.w_zero = (comp[3] == 0);
        if (!r.w_zero) begin
            for (int c = 0; c < 3; c++) begin
                num = 128'(comp[c]) <<< FRAC;
                quo = num / 128'(comp[3]);
                comp[c] = clip(quo, sat);
            end
            r.out_x = comp[0][31:0];
            r.out_y = comp[1][31:0];
            r.out_z = comp[2][31:0];
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            3: return 32'h00010000;
            default: return $urandom();
        endcase
    endfunction

    // send one item; queue its result if it is a transform
    task automatic send_item(input in_t it, input logic use_typed, input out_t typed);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.opcode == OP_LOAD) begin
            mat[it.entry_index] = it.entry_value;
        end else begin
            expected_q.push_back(use_typed ? typed : project_point(it));
        end
    endtask

    function automatic in_t load_item(input int idx, input logic [31:0] v);
        in_t it;
        it.opcode = OP_LOAD;
        it.entry_index = idx[3:0];
        it.entry_value = v;
        it.point_x = $urandom();
        it.point_y = $urandom();
        it.point_z = $urandom();
        return it;
    endfunction

    function automatic in_t point_item(input logic [31:0] x, y, z);
        in_t it;
        it.opcode = OP_TRANSFORM;
        it.entry_index = 4'($urandom());
        it.entry_value = $urandom();
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    // receiver side with random stalls
    always @(posedge aclk) begin
        if (m_ready && m_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                out_t e;
                e = expected_q.pop_front();
                if (e.out_x !== m_data.out_x) begin
                    $error("out_x exp %h got %h", e.out_x, m_data.out_x); errors++;
                end
                if (e.out_y !== m_data.out_y) begin
                    $error("out_y exp %h got %h", e.out_y, m_data.out_y); errors++;
                end
                if (e.out_z !== m_data.out_z) begin
                    $error("out_z exp %h got %h", e.out_z, m_data.out_z); errors++;
                end
                if (e.out_w !== m_data.out_w) begin
                    $error("out_w exp %h got %h", e.out_w, m_data.out_w); errors++;
                end
                if (e.w_zero !== m_data.w_zero) begin
                    $error("w_zero exp %b got %b", e.w_zero, m_data.w_zero); errors++;
                end
                if (e.saturated !== m_data.saturated) begin
                    $error("saturated exp %b got %b", e.saturated, m_data.saturated);
                    errors++;
                end
            end
        end
        // stall runs, most short and a few long
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt > 0) begin
            m_ready   <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else begin
            m_ready   <= 1'b1;
            stall_cnt <= ($urandom_range(0, 99) < 25) ? gap_len() : 0;
        end
    end

    typedef struct {
        in_t  item;
        logic typed;
        out_t res;
    } stim_row_t;

    stim_row_t dir_tab [$];

    initial begin
        in_t it;
        out_t r;
        for (int i = 0; i < MAT_ENTRIES; i++) mat[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity matrix, then zero w, then extremes
        for (int i = 0; i < MAT_ENTRIES; i++)
            dir_tab.push_back('{load_item(i, (i % 5 == 0) ? 32'h00010000 : 32'h0),
                                1'b0, '0});
        r = '0; r.out_x = 32'h00020000; r.out_y = 32'hfffd0000; r.out_z = 32'h0;
        r.out_w = 32'h00010000;
        dir_tab.push_back('{point_item(32'h00020000, 32'hfffd0000, 32'h0), 1'b1, r});
        dir_tab.push_back('{load_item(15, 32'h0), 1'b0, '0});
        r = '0; r.w_zero = 1'b1;
        dir_tab.push_back('{point_item(32'h7fffffff, 32'h80000000, 32'h12345678), 1'b1, r});
        dir_tab.push_back('{load_item(15, 32'h00000001), 1'b0, '0});
        dir_tab.push_back('{point_item(32'h7fffffff, 32'h80000000, 32'h00000001), 1'b0, '0});
        dir_tab.push_back('{load_item(0, 32'h7fffffff), 1'b0, '0});
        dir_tab.push_back('{load_item(5, 32'h80000000), 1'b0, '0});
        dir_tab.push_back('{point_item(32'h7fffffff, 32'h80000000, 32'hffffffff), 1'b0, '0});
        foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

        // random: loads and transforms mixed, most of them transforms
        for (int n = 0; n < N_RAND; n++) begin
            if ($urandom_range(0, 99) < 35)
                it = load_item($urandom_range(0, 15), rand_word());
            else
                it = point_item(rand_word(), rand_word(), rand_word());
            send_item(it, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
